// File: rtl/core/tuvd_pkg.sv
// ---------------------------------------------------------------------------
// tuvd_pkg
// shared widths, codes and the cordic angle table of the uv distortion check
// ---------------------------------------------------------------------------
`default_nettype none

package tuvd_pkg;

    localparam int POS_WIDTH  = 24;
    localparam int UV_WIDTH   = 20;
    localparam int EDGE_W     = ((POS_WIDTH > UV_WIDTH) ? POS_WIDTH : UV_WIDTH) + 1;
    localparam int NORM_BITS  = 24;
    localparam int MUL_W      = 33;
    localparam int ACC_W      = 52;
    localparam int CORD_W     = 36;
    localparam int Z_W        = 23;
    localparam int ANG_W      = 14;
    localparam int CNT_W      = 5;
    localparam int MAX_DIFF_W = 14;
    localparam int AREA_W     = 32;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [EDGE_W-1:0] t_edge;
    typedef logic signed [UV_WIDTH:0] t_uv_edge;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_ANGLE = 2'd1,
        FAULT_AREA  = 2'd2,
        FAULT_DEGEN = 2'd3
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DIFF = 2'd0,
        CFG_AREA_MIN = 2'd1,
        CFG_AREA_MAX = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic [ANG_W-1:0] angle;
    } t_corner_rsp;

    // atan(2^-i) in units of 2^-20 rad
    function automatic logic [Z_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = Z_W'(823550);
            5'd1:    v = Z_W'(486171);
            5'd2:    v = Z_W'(256879);
            5'd3:    v = Z_W'(130396);
            5'd4:    v = Z_W'(65451);
            5'd5:    v = Z_W'(32757);
            5'd6:    v = Z_W'(16383);
            5'd7:    v = Z_W'(8192);
            5'd8:    v = Z_W'(4096);
            5'd9:    v = Z_W'(2048);
            5'd10:   v = Z_W'(1024);
            5'd11:   v = Z_W'(512);
            5'd12:   v = Z_W'(256);
            5'd13:   v = Z_W'(128);
            5'd14:   v = Z_W'(64);
            5'd15:   v = Z_W'(32);
            5'd16:   v = Z_W'(16);
            5'd17:   v = Z_W'(8);
            5'd18:   v = Z_W'(4);
            5'd19:   v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tuvd_vtx_if.sv
// ---------------------------------------------------------------------------
// tuvd_vtx_if
// vertex channel: position and texture coordinate with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface tuvd_vtx_if;
    import tuvd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [UV_WIDTH-1:0]  tex_u;
    logic signed [UV_WIDTH-1:0]  tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tuvd_res_if.sv
// ---------------------------------------------------------------------------
// tuvd_res_if
// verdict channel: one transfer per closed triangle
// ---------------------------------------------------------------------------
`default_nettype none

interface tuvd_res_if;
    logic       valid;
    logic       ready;
    logic       is_bad;
    logic [1:0] fault_kind;

    modport source (output valid, is_bad, fault_kind, input ready);
    modport sink   (input valid, is_bad, fault_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tuvd_corner.sv
// ---------------------------------------------------------------------------
// tuvd_corner
// iterative corner angle unit: dot products, roots, divide and cordic acos
// ---------------------------------------------------------------------------
`default_nettype none

module tuvd_corner (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire tuvd_pkg::t_edge      i_p [3],
    input  wire tuvd_pkg::t_edge      i_q [3],
    output tuvd_pkg::t_corner_rsp     o_rsp
);
    import tuvd_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE, C_NORM, C_MAC, C_SQLD, C_SQRT, C_DEN, C_DSET, C_DIV, C_SIGN,
        C_CORD, C_OUT
    } t_state;

    typedef enum logic [1:0] {SQ_LP, SQ_LQ, SQ_X, SQ_Y} t_sq_sel;

    localparam logic signed [EDGE_W:0] POS_LIM = (EDGE_W+1)'(1) <<< NORM_BITS;
    localparam logic signed [EDGE_W:0] NEG_LIM = -POS_LIM;

    t_state                    r_state;
    t_sq_sel                   r_sel;
    logic [CNT_W-1:0]          r_cnt;
    t_edge                     r_a [3];
    t_edge                     r_b [3];
    logic signed [ACC_W-1:0]   r_d;
    logic [ACC_W-1:0]          r_pp;
    logic [ACC_W-1:0]          r_qq;
    logic [63:0]               r_rad;
    logic [63:0]               r_res;
    logic [31:0]               r_lp;
    logic [31:0]               r_lq;
    logic [63:0]               r_den;
    logic [63:0]               r_rem;
    logic signed [31:0]        r_c;
    logic signed [CORD_W-1:0]  r_x;
    logic signed [CORD_W-1:0]  r_y;
    logic signed [Z_W-1:0]     r_z;
    logic                      r_done;
    logic [ANG_W-1:0]          r_angle;

    logic signed [MUL_W-1:0]   m_a;
    logic signed [MUL_W-1:0]   m_b;
    logic signed [2*MUL_W-1:0] m_prod;
    logic                      too_big;
    logic [63:0]               sq_bit;
    logic [63:0]               sq_sum;
    logic                      sq_take;
    logic [63:0]               n_rad;
    logic [63:0]               n_res;
    logic [63:0]               num;
    logic [63:0]               n_rem;
    logic [32:0]               one_p_c;
    logic [32:0]               one_m_c;
    logic [Z_W-1:0]            z_pos;
    logic [Z_W:0]              z_rnd;

    // one shared multiplier for the dot products and the length product
    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == C_DEN) begin
            m_a = MUL_W'(r_lp);
            m_b = MUL_W'(r_lq);
        end else begin
            unique case (r_cnt)
                5'd0: begin m_a = MUL_W'(r_a[0]); m_b = MUL_W'(r_b[0]); end
                5'd1: begin m_a = MUL_W'(r_a[1]); m_b = MUL_W'(r_b[1]); end
                5'd2: begin m_a = MUL_W'(r_a[2]); m_b = MUL_W'(r_b[2]); end
                5'd3: begin m_a = MUL_W'(r_a[0]); m_b = MUL_W'(r_a[0]); end
                5'd4: begin m_a = MUL_W'(r_a[1]); m_b = MUL_W'(r_a[1]); end
                5'd5: begin m_a = MUL_W'(r_a[2]); m_b = MUL_W'(r_a[2]); end
                5'd6: begin m_a = MUL_W'(r_b[0]); m_b = MUL_W'(r_b[0]); end
                5'd7: begin m_a = MUL_W'(r_b[1]); m_b = MUL_W'(r_b[1]); end
                5'd8: begin m_a = MUL_W'(r_b[2]); m_b = MUL_W'(r_b[2]); end
                default: begin m_a = '0; m_b = '0; end
            endcase
        end
    end
    assign m_prod = m_a * m_b;

    always_comb begin
        too_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if ((EDGE_W+1)'(r_a[i]) >= POS_LIM || (EDGE_W+1)'(r_a[i]) <= NEG_LIM ||
                (EDGE_W+1)'(r_b[i]) >= POS_LIM || (EDGE_W+1)'(r_b[i]) <= NEG_LIM)
                too_big = 1'b1;
        end
    end

    // one bit of the square root per cycle
    assign sq_bit  = 64'(1) << (7'd62 - 7'({r_cnt, 1'b0}));
    assign sq_sum  = r_res + sq_bit;
    assign sq_take = (r_rad >= sq_sum);
    assign n_rad   = sq_take ? (r_rad - sq_sum) : r_rad;
    assign n_res   = sq_take ? ((r_res >> 1) + sq_bit) : (r_res >> 1);

    assign num     = (r_d < 0) ? (64'(-r_d) << 12) : (64'(r_d) << 12);
    assign n_rem   = r_rem << 1;
    assign one_p_c = (33'(1) << 30) + 33'(r_c);
    assign one_m_c = (33'(1) << 30) - 33'(r_c);
    assign z_pos   = (r_z < 0) ? '0 : Z_W'(r_z);
    assign z_rnd   = ({z_pos, 1'b0} + (Z_W+1)'(128)) >> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_sel   <= SQ_LP;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_p;
                        r_b     <= i_q;
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (too_big) begin
                        for (int i = 0; i < 3; i++) begin
                            r_a[i] <= r_a[i] >>> 1;
                            r_b[i] <= r_b[i] >>> 1;
                        end
                    end else begin
                        r_d     <= '0;
                        r_pp    <= '0;
                        r_qq    <= '0;
                        r_cnt   <= '0;
                        r_state <= C_MAC;
                    end
                end
                C_MAC: begin
                    if (r_cnt < 5'd3)      r_d  <= r_d + ACC_W'(m_prod);
                    else if (r_cnt < 5'd6) r_pp <= r_pp + ACC_W'(m_prod);
                    else                   r_qq <= r_qq + ACC_W'(m_prod);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd8) begin
                        r_sel   <= SQ_LP;
                        r_state <= C_SQLD;
                    end
                end
                C_SQLD: begin
                    r_cnt <= '0;
                    r_res <= '0;
                    unique case (r_sel)
                        SQ_LP: r_rad <= 64'(r_pp) << 12;
                        SQ_LQ: r_rad <= 64'(r_qq) << 12;
                        SQ_X:  r_rad <= 64'(one_p_c) << 30;
                        SQ_Y:  r_rad <= 64'(one_m_c) << 30;
                    endcase
                    r_state <= C_SQRT;
                end
                C_SQRT: begin
                    r_rad <= n_rad;
                    r_res <= n_res;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_cnt <= '0;
                        unique case (r_sel)
                            SQ_LP: begin
                                r_lp    <= n_res[31:0];
                                r_sel   <= SQ_LQ;
                                r_state <= C_SQLD;
                            end
                            SQ_LQ: begin
                                r_lq    <= n_res[31:0];
                                r_state <= C_DEN;
                            end
                            SQ_X: begin
                                r_x     <= CORD_W'(n_res[32:0]);
                                r_sel   <= SQ_Y;
                                r_state <= C_SQLD;
                            end
                            SQ_Y: begin
                                r_y     <= CORD_W'(n_res[32:0]);
                                r_z     <= '0;
                                r_state <= C_CORD;
                            end
                        endcase
                    end
                end
                C_DEN: begin
                    r_den   <= m_prod[63:0];
                    r_state <= C_DSET;
                end
                C_DSET: begin
                    r_cnt <= '0;
                    if (r_den == '0) begin
                        r_c     <= '0;
                        r_state <= C_SIGN;
                    end else if (num >= r_den) begin
                        r_c     <= 32'sd1 <<< 30;
                        r_state <= C_SIGN;
                    end else begin
                        r_rem   <= num;
                        r_c     <= '0;
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    if (n_rem >= r_den) begin
                        r_rem <= n_rem - r_den;
                        r_c   <= {r_c[30:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_c   <= {r_c[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd29) r_state <= C_SIGN;
                end
                C_SIGN: begin
                    if (r_d < 0) r_c <= -r_c;
                    r_sel   <= SQ_X;
                    r_state <= C_SQLD;
                end
                C_CORD: begin
                    if (r_y > 0) begin
                        r_x <= r_x + (r_y >>> r_cnt);
                        r_y <= r_y - (r_x >>> r_cnt);
                        r_z <= r_z + $signed(atan_entry(r_cnt));
                    end else begin
                        r_x <= r_x - (r_y >>> r_cnt);
                        r_y <= r_y + (r_x >>> r_cnt);
                        r_z <= r_z - $signed(atan_entry(r_cnt));
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd19) r_state <= C_OUT;
                end
                C_OUT: begin
                    r_angle <= ANG_W'(z_rnd);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_angle;

endmodule

`default_nettype wire

// File: rtl/core/triangle_uv_distortion_check.sv
// ---------------------------------------------------------------------------
// triangle_uv_distortion_check
// judges each triangle of a vertex stream for uv mapping distortion
// ---------------------------------------------------------------------------
// usage:
//   vertices come in on i_vtx (valid/ready), one transfer per vertex; every
//   third vertex closes a triangle and one verdict leaves on o_res
//   the first two vertices of a triangle are taken in one cycle each
//   the closing vertex starts the check: up to six corner angles are run
//   one after another through a single iterative angle unit (dot products
//   on one shared multiplier, four bit-serial square roots, a 30-step
//   divide and a 20-step cordic); corners with a zero-length side are
//   skipped and an angle mismatch ends the check early
//   i_vtx.ready is low while a triangle is being checked
//   the verdict sits in an output register; if o_res is stalled the
//   vertices of the next triangle are still taken and its check runs, then
//   the block waits with i_vtx.ready low until the old verdict left
//   configuration: i_cfg_we writes register i_cfg_idx (0 max angle diff,
//   1 uv area min, 2 uv area max); write only while idle
//   reset (synchronous, active low) clears the vertex count, loads the
//   register defaults and empties the output register
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_uv_distortion_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tuvd_vtx_if.sink                               i_vtx,
    tuvd_res_if.source                             o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [tuvd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tuvd_pkg::AREA_W-1:0]       i_cfg_data
);
    import tuvd_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE, T_CORNER, T_WAIT, T_AREA_A, T_AREA_B, T_CHECK, T_OUT
    } t_state;

    t_state                      r_state;
    logic [1:0]                  r_cnt;
    logic [1:0]                  r_ci;
    logic                        r_side;
    logic [ANG_W-1:0]            r_a3;
    t_fault                      r_fault;
    logic [MAX_DIFF_W-1:0]       r_max_diff;
    logic [AREA_W-1:0]           r_area_min;
    logic [AREA_W-1:0]           r_area_max;
    logic                        r_out_valid;
    logic                        r_out_bad;
    t_fault                      r_out_kind;
    logic [2*UV_WIDTH+1:0]       r_ma;
    logic [2*UV_WIDTH+1:0]       r_mb;

    // held vertices, written at the vertex count
    logic signed [POS_WIDTH-1:0] r_px [3];
    logic signed [POS_WIDTH-1:0] r_py [3];
    logic signed [POS_WIDTH-1:0] r_pz [3];
    logic signed [UV_WIDTH-1:0]  r_tu [3];
    logic signed [UV_WIDTH-1:0]  r_tv [3];

    // edges: 0 = ab, 1 = ac, 2 = bc
    t_edge                       e3 [3][3];
    t_uv_edge                    eu [3][2];
    logic                        z3 [3];
    logic                        zu [3];
    t_edge                       op_p [3];
    t_edge                       op_q [3];
    logic                        skip;
    logic                        start;
    t_corner_rsp                 rsp;
    logic [ANG_W-1:0]            diff;
    logic [UV_WIDTH:0]           mag_u0;
    logic [UV_WIDTH:0]           mag_v1;
    logic [UV_WIDTH:0]           mag_v0;
    logic [UV_WIDTH:0]           mag_u1;
    logic                        sa;
    logic                        sb;
    logic [2*UV_WIDTH+2:0]       uv_cross;
    logic                        accept;
    logic                        out_load;

    always_comb begin
        e3[0][0] = t_edge'(r_px[1]) - t_edge'(r_px[0]);
        e3[0][1] = t_edge'(r_py[1]) - t_edge'(r_py[0]);
        e3[0][2] = t_edge'(r_pz[1]) - t_edge'(r_pz[0]);
        e3[1][0] = t_edge'(r_px[2]) - t_edge'(r_px[0]);
        e3[1][1] = t_edge'(r_py[2]) - t_edge'(r_py[0]);
        e3[1][2] = t_edge'(r_pz[2]) - t_edge'(r_pz[0]);
        e3[2][0] = t_edge'(r_px[2]) - t_edge'(r_px[1]);
        e3[2][1] = t_edge'(r_py[2]) - t_edge'(r_py[1]);
        e3[2][2] = t_edge'(r_pz[2]) - t_edge'(r_pz[1]);
        eu[0][0] = t_uv_edge'(r_tu[1]) - t_uv_edge'(r_tu[0]);
        eu[0][1] = t_uv_edge'(r_tv[1]) - t_uv_edge'(r_tv[0]);
        eu[1][0] = t_uv_edge'(r_tu[2]) - t_uv_edge'(r_tu[0]);
        eu[1][1] = t_uv_edge'(r_tv[2]) - t_uv_edge'(r_tv[0]);
        eu[2][0] = t_uv_edge'(r_tu[2]) - t_uv_edge'(r_tu[1]);
        eu[2][1] = t_uv_edge'(r_tv[2]) - t_uv_edge'(r_tv[1]);
        for (int i = 0; i < 3; i++) begin
            z3[i] = (e3[i][0] == '0) && (e3[i][1] == '0) && (e3[i][2] == '0);
            zu[i] = (eu[i][0] == '0) && (eu[i][1] == '0);
        end
    end

    // corner a: ab, ac; corner b: ba, bc; corner c: ac, bc
    always_comb begin
        op_p = e3[0];
        op_q = e3[1];
        skip = 1'b0;
        unique case (r_ci)
            2'd0: begin
                skip = z3[0] || z3[1] || zu[0] || zu[1];
                if (!r_side) begin
                    op_p = e3[0];
                    op_q = e3[1];
                end else begin
                    op_p = '{t_edge'(eu[0][0]), t_edge'(eu[0][1]), '0};
                    op_q = '{t_edge'(eu[1][0]), t_edge'(eu[1][1]), '0};
                end
            end
            2'd1: begin
                skip = z3[0] || z3[2] || zu[0] || zu[2];
                if (!r_side) begin
                    op_p = '{-e3[0][0], -e3[0][1], -e3[0][2]};
                    op_q = e3[2];
                end else begin
                    op_p = '{-t_edge'(eu[0][0]), -t_edge'(eu[0][1]), '0};
                    op_q = '{t_edge'(eu[2][0]), t_edge'(eu[2][1]), '0};
                end
            end
            2'd2: begin
                skip = z3[1] || z3[2] || zu[1] || zu[2];
                if (!r_side) begin
                    op_p = e3[1];
                    op_q = e3[2];
                end else begin
                    op_p = '{t_edge'(eu[1][0]), t_edge'(eu[1][1]), '0};
                    op_q = '{t_edge'(eu[2][0]), t_edge'(eu[2][1]), '0};
                end
            end
            default: skip = 1'b0;
        endcase
    end

    assign start = (r_state == T_CORNER) && (r_ci != 2'd3) && !skip;

    tuvd_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_p     (op_p),
        .i_q     (op_q),
        .o_rsp   (rsp)
    );

    assign diff = (r_a3 > rsp.angle) ? (r_a3 - rsp.angle) : (rsp.angle - r_a3);

    // twice the uv area as |u0*v1 - v0*u1|, by sign and magnitude
    assign mag_u0 = eu[0][0][UV_WIDTH] ? (UV_WIDTH+1)'(-eu[0][0]) : (UV_WIDTH+1)'(eu[0][0]);
    assign mag_v1 = eu[1][1][UV_WIDTH] ? (UV_WIDTH+1)'(-eu[1][1]) : (UV_WIDTH+1)'(eu[1][1]);
    assign mag_v0 = eu[0][1][UV_WIDTH] ? (UV_WIDTH+1)'(-eu[0][1]) : (UV_WIDTH+1)'(eu[0][1]);
    assign mag_u1 = eu[1][0][UV_WIDTH] ? (UV_WIDTH+1)'(-eu[1][0]) : (UV_WIDTH+1)'(eu[1][0]);
    assign sa     = eu[0][0][UV_WIDTH] != eu[1][1][UV_WIDTH];
    assign sb     = eu[0][1][UV_WIDTH] != eu[1][0][UV_WIDTH];
    assign uv_cross = (sa == sb) ?
                    ((r_ma > r_mb) ? (2*UV_WIDTH+3)'(r_ma - r_mb) : (2*UV_WIDTH+3)'(r_mb - r_ma)) :
                    ((2*UV_WIDTH+3)'(r_ma) + (2*UV_WIDTH+3)'(r_mb));

    assign i_vtx.ready = (r_state == T_IDLE);
    assign accept      = i_vtx.valid && (r_state == T_IDLE);

    // verdict loads when the output register is empty or leaving this cycle
    assign out_load    = (r_state == T_OUT) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_cnt       <= '0;
            r_ci        <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_diff  <= MAX_DIFF_W'(715);
            r_area_min  <= AREA_W'(16777);
            r_area_max  <= AREA_W'(83886080);
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_DIFF: r_max_diff <= i_cfg_data[MAX_DIFF_W-1:0];
                    CFG_AREA_MIN: r_area_min <= i_cfg_data;
                    CFG_AREA_MAX: r_area_max <= i_cfg_data;
                    CFG_UNUSED:   ;
                endcase
            end
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;

            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_px[r_cnt] <= i_vtx.pos_x;
                        r_py[r_cnt] <= i_vtx.pos_y;
                        r_pz[r_cnt] <= i_vtx.pos_z;
                        r_tu[r_cnt] <= i_vtx.tex_u;
                        r_tv[r_cnt] <= i_vtx.tex_v;
                        if (r_cnt == 2'd2) begin
                            r_cnt   <= '0;
                            r_ci    <= '0;
                            r_side  <= 1'b0;
                            r_fault <= FAULT_OK;
                            r_state <= T_CORNER;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                T_CORNER: begin
                    if (r_ci == 2'd3) r_state <= T_AREA_A;
                    else if (skip)    r_ci    <= r_ci + 1'b1;
                    else              r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (rsp.done) begin
                        if (!r_side) begin
                            r_a3    <= rsp.angle;
                            r_side  <= 1'b1;
                            r_state <= T_CORNER;
                        end else if (diff > ANG_W'(r_max_diff)) begin
                            r_fault <= FAULT_ANGLE;
                            r_state <= T_OUT;
                        end else begin
                            r_side  <= 1'b0;
                            r_ci    <= r_ci + 1'b1;
                            r_state <= T_CORNER;
                        end
                    end
                end
                T_AREA_A: begin
                    r_ma    <= mag_u0 * mag_v1;
                    r_state <= T_AREA_B;
                end
                T_AREA_B: begin
                    r_mb    <= mag_v0 * mag_u1;
                    r_state <= T_CHECK;
                end
                T_CHECK: begin
                    // area limits, then 3d triangle collapsed to a point, then uv collapsed to a point
                    if (uv_cross < (2*UV_WIDTH+3)'({r_area_min, 1'b0}) ||
                        uv_cross >= (2*UV_WIDTH+3)'({r_area_max, 1'b0}))
                        r_fault <= FAULT_AREA;
                    else if (z3[0] && z3[1])
                        r_fault <= FAULT_DEGEN;
                    else if (zu[0] && zu[1])
                        r_fault <= FAULT_AREA;
                    r_state <= T_OUT;
                end
                T_OUT: begin
                    if (out_load) begin
                        r_out_bad   <= (r_fault != FAULT_OK);
                        r_out_kind  <= r_fault;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.is_bad     = r_out_bad;
    assign o_res.fault_kind = r_out_kind;

endmodule

`default_nettype wire
